// ===== sv/ptid_pkg.sv =====
`timescale 1ns / 1ps
package ptid_pkg;

  localparam int COORD_BITS = 32;
  localparam int GEO_W      = 32;
  localparam int GEO_FRAC   = 30;
  localparam int ID_W       = 58;
  localparam int DEPTH_W    = 5;
  localparam int TOL_W      = 20;
  localparam int ACC_W      = 64;
  localparam int IT_W       = $clog2(GEO_W);

  localparam logic [GEO_W-1:0] GEO_ONE = GEO_W'(64'd1 << GEO_FRAC);

  // triangle selection codes
  localparam logic [2:0] TRI_C0   = 3'd0;
  localparam logic [2:0] TRI_C1   = 3'd1;
  localparam logic [2:0] TRI_C2   = 3'd2;
  localparam logic [2:0] TRI_C3   = 3'd3;
  localparam logic [2:0] TRI_ROOT = 3'd4;

  localparam logic [1:0] CHILD_LAST = 2'd3;
  localparam logic [1:0] EDG_LAST   = 2'd2;
  localparam logic [1:0] NSEL_LAST  = 2'd2;
  localparam logic [2:0] ROOT_LAST  = 3'd7;

  // register indexes
  localparam logic REG_DEPTH = 1'b0;
  localparam logic REG_TOL   = 1'b1;

  typedef logic [2:0][GEO_W-1:0] vec_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic signed [COORD_BITS-1:0] pz;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] trixel_id;
    logic            no_match;
  } out_item_t;

  typedef struct packed {
    logic       load_p;
    logic       root_load;
    logic [2:0] root;
    logic       tri_go;
    logic [2:0] tsel;
    logic [1:0] edg;
    logic       norm_go;
    logic [1:0] nsel;
    logic       commit;
    logic [1:0] child;
    logic       miss;
  } cmd_t;

  typedef struct packed {
    logic tri_done;
    logic tri_ge;
    logic norm_done;
  } stat_t;

  // octahedron vertices: k, i, j, -i, -j, -k
  function automatic vec_t axis_vec(input logic [2:0] k);
    vec_t v;
    v = '0;
    unique case (k)
      3'd0:    v[2] = GEO_ONE;
      3'd1:    v[0] = GEO_ONE;
      3'd2:    v[1] = GEO_ONE;
      3'd3:    v[0] = -GEO_ONE;
      3'd4:    v[1] = -GEO_ONE;
      3'd5:    v[2] = -GEO_ONE;
      default: v = '0;
    endcase
    return v;
  endfunction

  // vertex numbers of root triangles S0..S3, N0..N3
  function automatic logic [2:0][2:0] root_vtx(input logic [2:0] r);
    logic [2:0][2:0] t;
    unique case (r)
      3'd0:    begin t[0] = 3'd1; t[1] = 3'd5; t[2] = 3'd2; end
      3'd1:    begin t[0] = 3'd2; t[1] = 3'd5; t[2] = 3'd3; end
      3'd2:    begin t[0] = 3'd3; t[1] = 3'd5; t[2] = 3'd4; end
      3'd3:    begin t[0] = 3'd4; t[1] = 3'd5; t[2] = 3'd1; end
      3'd4:    begin t[0] = 3'd1; t[1] = 3'd0; t[2] = 3'd4; end
      3'd5:    begin t[0] = 3'd4; t[1] = 3'd0; t[2] = 3'd3; end
      3'd6:    begin t[0] = 3'd3; t[1] = 3'd0; t[2] = 3'd2; end
      default: begin t[0] = 3'd2; t[1] = 3'd0; t[2] = 3'd1; end
    endcase
    return t;
  endfunction

endpackage

// ===== sv/ptid_norm.sv =====
`timescale 1ns / 1ps
module ptid_norm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                go_i,
  input  ptid_pkg::vec_t      a_i,
  input  ptid_pkg::vec_t      b_i,
  output logic                done_o,
  output ptid_pkg::vec_t      res_o
);

  localparam int W     = ptid_pkg::GEO_W;
  localparam int NUM_W = 2 * W - 2;

  typedef enum logic [4:0] {
    N_IDLE = 5'b00001,
    N_SQ   = 5'b00010,
    N_SQRT = 5'b00100,
    N_DLD  = 5'b01000,
    N_DIT  = 5'b10000
  } nstate_e;

  nstate_e state_q, state_d;

  logic [2:0][W:0]           s_q;
  logic [1:0]                cnt_q;
  logic [2*W-1:0]            prod_q, sum_q, rad_q;
  logic [W+1:0]              rem_q;
  logic [W-1:0]              root_q;
  logic [ptid_pkg::IT_W-1:0] it_q;
  logic [W-1:0]              drem_q, dlow_q, q_q;
  ptid_pkg::vec_t            res_q;
  logic                      done_q;

  logic [W:0]       s_sel, mag_w;
  logic [W-1:0]     mag;
  logic [W+3:0]     rem2, trial;
  logic             sq_ge;
  logic [W+1:0]     rem_nx;
  logic [W-1:0]     root_nx;
  logic [NUM_W-1:0] num;
  logic [W:0]       r2;
  logic             d_ge;
  logic [W-1:0]     drem_nx, q_nx;

  always_comb begin
    unique case (cnt_q)
      2'd0:    s_sel = s_q[0];
      2'd1:    s_sel = s_q[1];
      default: s_sel = s_q[2];
    endcase
    mag_w = s_sel[W] ? (~s_sel + 1'b1) : s_sel;
    mag   = mag_w[W-1:0];

    // one root bit per step, from one radicand bit pair
    rem2    = {rem_q, rad_q[2*W-1 -: 2]};
    trial   = {2'b00, root_q, 2'b01};
    sq_ge   = rem2 >= trial;
    rem_nx  = sq_ge ? (W+2)'(rem2 - trial) : rem2[W+1:0];
    root_nx = {root_q[W-2:0], sq_ge};

    num = {mag, ptid_pkg::GEO_FRAC'(0)} + NUM_W'(root_q[W-1:1]);

    r2      = {drem_q, dlow_q[W-1]};
    d_ge    = r2 >= {1'b0, root_q};
    drem_nx = d_ge ? W'(r2 - {1'b0, root_q}) : r2[W-1:0];
    q_nx    = {q_q[W-2:0], d_ge};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      N_IDLE:  if (go_i) state_d = N_SQ;
      N_SQ:    if (cnt_q == 2'd3) state_d = N_SQRT;
      N_SQRT:  if (it_q == ptid_pkg::IT_W'(W - 1)) state_d = (root_nx == '0) ? N_IDLE : N_DLD;
      N_DLD:   state_d = N_DIT;
      N_DIT:   if (it_q == ptid_pkg::IT_W'(W - 1)) state_d = (cnt_q == 2'd2) ? N_IDLE : N_DLD;
      default: state_d = N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= ((state_q == N_SQRT) && (it_q == ptid_pkg::IT_W'(W - 1)) &&
                  (root_nx == '0)) ||
                 ((state_q == N_DIT) && (it_q == ptid_pkg::IT_W'(W - 1)) &&
                  (cnt_q == 2'd2));
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      N_IDLE: begin
        if (go_i) begin
          for (int i = 0; i < 3; i++) begin
            s_q[i] <= {a_i[i][W-1], a_i[i]} + {b_i[i][W-1], b_i[i]};
          end
          cnt_q <= '0;
          sum_q <= '0;
        end
      end
      N_SQ: begin
        if (cnt_q != 2'd3) prod_q <= (2*W)'(mag * mag);
        if (cnt_q != 2'd0) sum_q <= sum_q + prod_q;
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          rad_q  <= sum_q + prod_q;
          rem_q  <= '0;
          root_q <= '0;
          it_q   <= '0;
        end
      end
      N_SQRT: begin
        rem_q  <= rem_nx;
        root_q <= root_nx;
        rad_q  <= {rad_q[2*W-3:0], 2'b00};
        it_q   <= it_q + 1'b1;
        if (it_q == ptid_pkg::IT_W'(W - 1)) begin
          cnt_q <= '0;
          if (root_nx == '0) res_q <= '0;
        end
      end
      N_DLD: begin
        drem_q <= W'(num[NUM_W-1:W]);
        dlow_q <= num[W-1:0];
        q_q    <= '0;
        it_q   <= '0;
      end
      N_DIT: begin
        drem_q <= drem_nx;
        dlow_q <= {dlow_q[W-2:0], 1'b0};
        q_q    <= q_nx;
        it_q   <= it_q + 1'b1;
        if (it_q == ptid_pkg::IT_W'(W - 1)) begin
          // rounded half away from zero
          res_q[cnt_q] <= s_sel[W] ? (~q_nx + 1'b1) : q_nx;
          cnt_q        <= cnt_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== sv/ptid_triple.sv =====
`timescale 1ns / 1ps
module ptid_triple (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              go_i,
  input  ptid_pkg::vec_t                    a_i,
  input  ptid_pkg::vec_t                    b_i,
  input  ptid_pkg::vec_t                    p_i,
  input  logic signed [ptid_pkg::ACC_W-1:0] thr_i,
  output logic                              done_o,
  output logic                              ge_o
);

  localparam int W = ptid_pkg::GEO_W;
  localparam int A = ptid_pkg::ACC_W;

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_RUN  = 3'b010,
    T_CMP  = 3'b100
  } tstate_e;

  tstate_e state_q, state_d;

  ptid_pkg::vec_t   a_q, b_q;
  logic [1:0]       comp_q;
  logic [2:0]       ph_q;
  logic [A-1:0]     pa_q, pb_q, pc_q, acc_q, x;
  logic signed [W:0] c_q;
  logic             ge_q, done_q;

  logic [W-1:0]        aj, ak, bj, bk, pi;
  logic signed [W:0]   opa, opb;
  logic signed [2*W+1:0] mul;

  always_comb begin
    // component i of a x b is a[j]*b[k] - a[k]*b[j]
    unique case (comp_q)
      2'd0:    begin aj = a_q[1]; ak = a_q[2]; bj = b_q[1]; bk = b_q[2]; pi = p_i[0]; end
      2'd1:    begin aj = a_q[2]; ak = a_q[0]; bj = b_q[2]; bk = b_q[0]; pi = p_i[1]; end
      default: begin aj = a_q[0]; ak = a_q[1]; bj = b_q[0]; bk = b_q[1]; pi = p_i[2]; end
    endcase
    unique case (ph_q)
      3'd0:    begin opa = {aj[W-1], aj}; opb = {bk[W-1], bk}; end
      3'd1:    begin opa = {ak[W-1], ak}; opb = {bj[W-1], bj}; end
      default: begin opa = c_q;           opb = {pi[W-1], pi}; end
    endcase
    mul = opa * opb;
    x   = pa_q - pb_q + (A'(1) << (ptid_pkg::GEO_FRAC - 1));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE:  if (go_i) state_d = T_RUN;
      T_RUN:   if ((ph_q == 3'd4) && (comp_q == 2'd2)) state_d = T_CMP;
      T_CMP:   state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == T_CMP);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      T_IDLE: begin
        if (go_i) begin
          a_q    <= a_i;
          b_q    <= b_i;
          comp_q <= '0;
          ph_q   <= '0;
          acc_q  <= '0;
        end
      end
      T_RUN: begin
        unique case (ph_q)
          3'd0:    pa_q <= mul[A-1:0];
          3'd1:    pb_q <= mul[A-1:0];
          3'd2:    c_q  <= x[ptid_pkg::GEO_FRAC + W : ptid_pkg::GEO_FRAC];
          3'd3:    pc_q <= mul[A-1:0];
          default: acc_q <= acc_q + pc_q;
        endcase
        if (ph_q == 3'd4) begin
          ph_q   <= '0;
          comp_q <= comp_q + 2'd1;
        end else begin
          ph_q <= ph_q + 3'd1;
        end
      end
      T_CMP:   ge_q <= $signed(acc_q) >= thr_i;
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign ge_o   = ge_q;

endmodule

// ===== sv/ptid_dp.sv =====
`timescale 1ns / 1ps
module ptid_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ptid_pkg::cmd_t                    cmd_i,
  input  ptid_pkg::in_item_t                item_i,
  input  logic signed [ptid_pkg::ACC_W-1:0] thr_i,
  output ptid_pkg::stat_t                   stat_o,
  output logic [ptid_pkg::ID_W-1:0]         id_o,
  output logic                              miss_o
);

  localparam int W  = ptid_pkg::GEO_W;
  localparam int CB = ptid_pkg::COORD_BITS;

  ptid_pkg::vec_t p_q, v0_q, v1_q, v2_q, w0_q, w1_q, w2_q;
  ptid_pkg::vec_t p_in, ta, tb, na, nb, nres;
  ptid_pkg::vec_t t0, t1, t2;
  logic [2:0][2:0] rv;
  logic [ptid_pkg::ID_W-1:0] id_q;
  logic miss_q;

  // bring input coordinates to Q2.30
  if (CB >= W) begin : g_shr
    assign p_in[0] = W'($signed(item_i.px) >>> (CB - W));
    assign p_in[1] = W'($signed(item_i.py) >>> (CB - W));
    assign p_in[2] = W'($signed(item_i.pz) >>> (CB - W));
  end else begin : g_shl
    assign p_in[0] = {item_i.px, {(W - CB){1'b0}}};
    assign p_in[1] = {item_i.py, {(W - CB){1'b0}}};
    assign p_in[2] = {item_i.pz, {(W - CB){1'b0}}};
  end

  always_comb begin
    unique case (cmd_i.tsel)
      ptid_pkg::TRI_C0: begin t0 = v0_q; t1 = w2_q; t2 = w1_q; end
      ptid_pkg::TRI_C1: begin t0 = v1_q; t1 = w0_q; t2 = w2_q; end
      ptid_pkg::TRI_C2: begin t0 = v2_q; t1 = w1_q; t2 = w0_q; end
      ptid_pkg::TRI_C3: begin t0 = w0_q; t1 = w1_q; t2 = w2_q; end
      default:          begin t0 = v0_q; t1 = v1_q; t2 = v2_q; end
    endcase
    unique case (cmd_i.edg)
      2'd0:    begin ta = t0; tb = t1; end
      2'd1:    begin ta = t1; tb = t2; end
      default: begin ta = t2; tb = t0; end
    endcase
    unique case (cmd_i.nsel)
      2'd0:    begin na = v1_q; nb = v2_q; end
      2'd1:    begin na = v0_q; nb = v2_q; end
      default: begin na = v1_q; nb = v0_q; end
    endcase
    rv = ptid_pkg::root_vtx(cmd_i.root);
  end

  ptid_triple u_triple (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.tri_go),
    .a_i    (ta),
    .b_i    (tb),
    .p_i    (p_q),
    .thr_i  (thr_i),
    .done_o (stat_o.tri_done),
    .ge_o   (stat_o.tri_ge)
  );

  ptid_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.norm_go),
    .a_i    (na),
    .b_i    (nb),
    .done_o (stat_o.norm_done),
    .res_o  (nres)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_p) p_q <= p_in;
    if (cmd_i.root_load) begin
      v0_q <= ptid_pkg::axis_vec(rv[0]);
      v1_q <= ptid_pkg::axis_vec(rv[1]);
      v2_q <= ptid_pkg::axis_vec(rv[2]);
    end else if (cmd_i.commit) begin
      unique case (cmd_i.child)
        2'd0:    begin v1_q <= w2_q; v2_q <= w1_q; end
        2'd1:    begin v0_q <= v1_q; v1_q <= w0_q; v2_q <= w2_q; end
        2'd2:    begin v0_q <= v2_q; v1_q <= w1_q; v2_q <= w0_q; end
        default: begin v0_q <= w0_q; v1_q <= w1_q; v2_q <= w2_q; end
      endcase
    end
    if (stat_o.norm_done) begin
      unique case (cmd_i.nsel)
        2'd0:    w0_q <= nres;
        2'd1:    w1_q <= nres;
        default: w2_q <= nres;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q   <= '0;
      miss_q <= 1'b0;
    end else begin
      if (cmd_i.root_load) begin
        id_q <= ptid_pkg::ID_W'({1'b1, cmd_i.root});
      end else if (cmd_i.commit) begin
        id_q <= {id_q[ptid_pkg::ID_W-3:0], cmd_i.child};
      end
      if (cmd_i.load_p) begin
        miss_q <= 1'b0;
      end else if (cmd_i.miss) begin
        miss_q <= 1'b1;
      end
    end
  end

  assign id_o   = id_q;
  assign miss_o = miss_q;

endmodule

// ===== sv/ptid_ctrl.sv =====
`timescale 1ns / 1ps
module ptid_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic [ptid_pkg::DEPTH_W-1:0]  depth_i,
  input  ptid_pkg::stat_t               stat_i,
  output ptid_pkg::cmd_t                cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_RLD  = 10'b0000000010,
    S_RGO  = 10'b0000000100,
    S_RWT  = 10'b0000001000,
    S_LCHK = 10'b0000010000,
    S_NGO  = 10'b0000100000,
    S_NWT  = 10'b0001000000,
    S_CGO  = 10'b0010000000,
    S_CWT  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [2:0] root_q, root_d;
  logic [1:0] edg_q, edg_d, ch_q, ch_d, nsel_q, nsel_d;
  logic [ptid_pkg::DEPTH_W-1:0] lvl_q, lvl_d;

  always_comb begin
    state_d = state_q;
    root_d  = root_q;
    edg_d   = edg_q;
    ch_d    = ch_q;
    nsel_d  = nsel_q;
    lvl_d   = lvl_q;

    cmd_o           = '0;
    cmd_o.root      = root_q;
    cmd_o.tsel      = (state_q == S_RGO) ? ptid_pkg::TRI_ROOT : {1'b0, ch_q};
    cmd_o.edg       = edg_q;
    cmd_o.nsel      = nsel_q;
    cmd_o.child     = ch_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_p = 1'b1;
          root_d       = '0;
          state_d      = S_RLD;
        end
      end
      S_RLD: begin
        cmd_o.root_load = 1'b1;
        edg_d           = '0;
        state_d         = S_RGO;
      end
      S_RGO: begin
        cmd_o.tri_go = 1'b1;
        state_d      = S_RWT;
      end
      S_RWT: begin
        if (stat_i.tri_done) begin
          if (!stat_i.tri_ge) begin
            if (root_q == ptid_pkg::ROOT_LAST) begin
              // no root holds the point: keep N3
              cmd_o.miss = 1'b1;
              lvl_d      = '0;
              state_d    = S_LCHK;
            end else begin
              root_d  = root_q + 3'd1;
              state_d = S_RLD;
            end
          end else if (edg_q == ptid_pkg::EDG_LAST) begin
            lvl_d   = '0;
            state_d = S_LCHK;
          end else begin
            edg_d   = edg_q + 2'd1;
            state_d = S_RGO;
          end
        end
      end
      S_LCHK: begin
        if (lvl_q == depth_i) begin
          state_d = S_OUT;
        end else begin
          nsel_d  = '0;
          state_d = S_NGO;
        end
      end
      S_NGO: begin
        cmd_o.norm_go = 1'b1;
        state_d       = S_NWT;
      end
      S_NWT: begin
        if (stat_i.norm_done) begin
          if (nsel_q == ptid_pkg::NSEL_LAST) begin
            ch_d    = '0;
            edg_d   = '0;
            state_d = S_CGO;
          end else begin
            nsel_d  = nsel_q + 2'd1;
            state_d = S_NGO;
          end
        end
      end
      S_CGO: begin
        cmd_o.tri_go = 1'b1;
        state_d      = S_CWT;
      end
      S_CWT: begin
        if (stat_i.tri_done) begin
          if (!stat_i.tri_ge) begin
            if (ch_q == ptid_pkg::CHILD_LAST) begin
              // centre child taken even though it failed
              cmd_o.commit = 1'b1;
              cmd_o.miss   = 1'b1;
              lvl_d        = lvl_q + 1'b1;
              state_d      = S_LCHK;
            end else begin
              ch_d    = ch_q + 2'd1;
              edg_d   = '0;
              state_d = S_CGO;
            end
          end else if (edg_q == ptid_pkg::EDG_LAST) begin
            cmd_o.commit = 1'b1;
            lvl_d        = lvl_q + 1'b1;
            state_d      = S_LCHK;
          end else begin
            edg_d   = edg_q + 2'd1;
            state_d = S_CGO;
          end
        end
      end
      S_OUT: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      root_q  <= '0;
      edg_q   <= '0;
      ch_q    <= '0;
      nsel_q  <= '0;
      lvl_q   <= '0;
    end else begin
      state_q <= state_d;
      root_q  <= root_d;
      edg_q   <= edg_d;
      ch_q    <= ch_d;
      nsel_q  <= nsel_d;
      lvl_q   <= lvl_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

endmodule

// ===== sv/point_to_trixel_id_core.sv =====
`timescale 1ns / 1ps
// Locates a Q2.30 point on the octahedral triangular mesh and returns its trixel id
// (root code 8..15, then two bits per level) with a no_match flag. One item is worked
// at a time. The root search tries up to eight roots, each a load step plus 1 to 3
// triple products. Each level then takes three midpoint normalizations (4 square
// steps, a 32-step square root and three 32-step dividers in one shared normalize
// unit) plus 3 to 12 triple products on one multiplier. The result is held until
// taken before the next item is accepted.
module point_to_trixel_id_core #(
  parameter int MAX_DEPTH = 27
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  ptid_pkg::in_item_t     in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output ptid_pkg::out_item_t    out_item_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int DW = ptid_pkg::DEPTH_W;
  localparam int TW = ptid_pkg::TOL_W;
  localparam int AW = ptid_pkg::ACC_W;

  logic [DW-1:0] depth_q, depth_eff;
  logic [TW-1:0] tol_q;
  logic signed [AW-1:0] thr;
  logic wr_en;

  ptid_pkg::cmd_t  cmd;
  ptid_pkg::stat_t stat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= DW'(10);
      tol_q   <= TW'(1);
    end else if (wr_en) begin
      unique case (paddr[2])
        ptid_pkg::REG_DEPTH: depth_q <= pwdata[DW-1:0];
        default:             tol_q   <= pwdata[TW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ptid_pkg::REG_DEPTH: prdata = 32'(depth_q);
      default:             prdata = 32'(tol_q);
    endcase
  end

  assign depth_eff = (depth_q > DW'(MAX_DEPTH)) ? DW'(MAX_DEPTH) : depth_q;
  assign thr       = -$signed(AW'({tol_q, {ptid_pkg::GEO_FRAC{1'b0}}}));

  ptid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .depth_i     (depth_eff),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ptid_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .item_i (in_item_i),
    .thr_i  (thr),
    .stat_o (stat),
    .id_o   (out_item_o.trixel_id),
    .miss_o (out_item_o.no_match)
  );

endmodule

// ===== tb/tb_point_to_trixel_id_core.sv =====
`timescale 1ns / 1ps
module tb_point_to_trixel_id_core;

  typedef longint gvec_t [3];

  localparam int WATCHDOG_LIMIT = 200000;
  localparam longint ONE = longint'(1) <<< 30;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  ptid_pkg::in_item_t   in_item_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b1;
  ptid_pkg::out_item_t  out_item_o;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [2:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  ptid_pkg::out_item_t  pending_ids[$];
  bit [4:0]    cfg_depth = 5'd10;
  bit [19:0]   cfg_tol = 20'd1;
  bit          no_gaps = 1'b0;
  int          fail_count = 0;
  int          idle_cycles = 0;

  point_to_trixel_id_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk_i = ~clk_i;

  // ---------------- geometry of the mesh ----------------
  function automatic void vertex(input int k, output gvec_t v);
    v = '{0, 0, 0};
    case (k)
      0: v[2] = ONE;
      1: v[0] = ONE;
      2: v[1] = ONE;
      3: v[0] = -ONE;
      4: v[1] = -ONE;
      default: v[2] = -ONE;
    endcase
  endfunction

  function automatic longint unsigned root64(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // normalized edge midpoint, rounded half away from zero
  function automatic void midpoint(input gvec_t a, input gvec_t b, output gvec_t r);
    longint s [3];
    longint unsigned sum, n, mag;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      s[i] = a[i] + b[i];
      mag = (s[i] < 0) ? longint'(-s[i]) : longint'(s[i]);
      sum += mag * mag;
    end
    n = root64(sum);
    for (int i = 0; i < 3; i++) begin
      if (n == 0) begin
        r[i] = 0;
      end else begin
        mag = (s[i] < 0) ? longint'(-s[i]) : longint'(s[i]);
        mag = ((mag << 30) + n / 2) / n;
        r[i] = (s[i] < 0) ? -longint'(mag) : longint'(mag);
      end
    end
  endfunction

  function automatic longint triple(input gvec_t a, input gvec_t b, input gvec_t p);
    longint x [3];
    longint c, acc;
    acc = 0;
    x[0] = a[1] * b[2] - a[2] * b[1];
    x[1] = a[2] * b[0] - a[0] * b[2];
    x[2] = a[0] * b[1] - a[1] * b[0];
    for (int i = 0; i < 3; i++) begin
      c = (x[i] + (longint'(1) <<< 29)) >>> 30;
      acc += c * p[i];
    end
    return acc;
  endfunction

  function automatic bit holds(input gvec_t p, input gvec_t a, input gvec_t b,
                               input gvec_t c, input longint thr);
    return triple(a, b, p) >= thr && triple(b, c, p) >= thr && triple(c, a, p) >= thr;
  endfunction

  function automatic ptid_pkg::out_item_t locate_trixel(input ptid_pkg::in_item_t it);
    int roots [8][3];
    gvec_t p, v0, v1, v2, w0, w1, w2, a, b, c;
    longint thr;
    int lim, root;
    bit miss;
    logic [63:0] id;
    logic [1:0] ch;
    ptid_pkg::out_item_t res;
    roots = '{'{1,5,2}, '{2,5,3}, '{3,5,4}, '{4,5,1},
              '{1,0,4}, '{4,0,3}, '{3,0,2}, '{2,0,1}};
    p[0] = longint'(it.px);
    p[1] = longint'(it.py);
    p[2] = longint'(it.pz);
    thr = -(longint'(cfg_tol) <<< 30);
    lim = (cfg_depth > 27) ? 27 : cfg_depth;
    root = -1;
    for (int r = 0; r < 8 && root < 0; r++) begin
      vertex(roots[r][0], a);
      vertex(roots[r][1], b);
      vertex(roots[r][2], c);
      if (holds(p, a, b, c, thr)) root = r;
    end
    miss = (root < 0);
    if (miss) root = 7;
    vertex(roots[root][0], v0);
    vertex(roots[root][1], v1);
    vertex(roots[root][2], v2);
    id = 64'd8 + root;
    for (int l = 0; l < lim; l++) begin
      midpoint(v1, v2, w0);
      midpoint(v0, v2, w1);
      midpoint(v1, v0, w2);
      if (holds(p, v0, w2, w1, thr)) begin
        ch = 2'd0; v1 = w2; v2 = w1;
      end else if (holds(p, v1, w0, w2, thr)) begin
        ch = 2'd1; v0 = v1; v1 = w0; v2 = w2;
      end else if (holds(p, v2, w1, w0, thr)) begin
        ch = 2'd2; v0 = v2; v1 = w1; v2 = w0;
      end else begin
        if (!holds(p, w0, w1, w2, thr)) miss = 1'b1;
        ch = 2'd3; v0 = w0; v1 = w1; v2 = w2;
      end
      id = (id << 2) | ch;
    end
    res.trixel_id = id[ptid_pkg::ID_W-1:0];
    res.no_match = miss;
    return res;
  endfunction

  // ---------------- drivers ----------------
  task automatic send_point(input ptid_pkg::in_item_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_ids.push_back(locate_trixel(it));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_ids.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    wait_drained();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == ptid_pkg::REG_DEPTH) cfg_depth = val[4:0];
    else cfg_tol = val[19:0];
    @(posedge clk_i);
  endtask

  function automatic ptid_pkg::in_item_t rand_point();
    ptid_pkg::in_item_t it;
    int mode;
    mode = $urandom_range(0, 9);
    it.px = $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
    it.py = $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
    it.pz = $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
    if (mode < 2) begin
      it.px = $urandom;
      it.py = $urandom;
      it.pz = $urandom;
    end else if (mode == 2) begin
      // on or near the plane x = y
      it.py = it.px + $signed($urandom_range(0, 8)) - 4;
    end else if (mode == 3) begin
      it.pz = $signed($urandom_range(0, 8)) - 4;
    end
    return it;
  endfunction

  // ---------------- tests ----------------
  task automatic test_directed();
    ptid_pkg::in_item_t pts[$];
    pts = '{'{0, 0, 0},
            '{32'sh4000_0000, 0, 0}, '{-32'sh4000_0000, 0, 0},
            '{0, 32'sh4000_0000, 0}, '{0, -32'sh4000_0000, 0},
            '{0, 0, 32'sh4000_0000}, '{0, 0, -32'sh4000_0000},
            '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff},
            '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000},
            '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0001},
            '{32'sh2000_0000, 32'sh2000_0000, 0},
            '{-32'sh2000_0000, 32'sh2000_0000, 0},
            '{32'sh24f3_4e8b, 32'sh24f3_4e8b, 32'sh24f3_4e8b},
            '{-32'sh24f3_4e8b, -32'sh24f3_4e8b, -32'sh24f3_4e8b},
            '{32'sh24f3_4e8b, -32'sh24f3_4e8b, 32'sh24f3_4e8b},
            '{-1, -1, -1},
            '{32'sh0000_0001, -32'sh0000_0001, 0}};
    foreach (pts[i]) send_point(pts[i]);
    write_reg(ptid_pkg::REG_TOL, 32'd0);
    write_reg(ptid_pkg::REG_DEPTH, 32'd0);
    foreach (pts[i]) if (i < 8) send_point(pts[i]);
  endtask

  task automatic test_shallow_random(input int n, input logic [4:0] d, input logic [19:0] t);
    write_reg(ptid_pkg::REG_DEPTH, {27'd0, d});
    write_reg(ptid_pkg::REG_TOL, {12'd0, t});
    for (int i = 0; i < n; i++) begin
      no_gaps = (i % 60) >= 45;
      send_point(rand_point());
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_drain_pauses();
    write_reg(ptid_pkg::REG_DEPTH, 32'd2);
    write_reg(ptid_pkg::REG_TOL, 32'hfffff);
    for (int i = 0; i < 40; i++) begin
      if (i % 8 == 0) wait_drained();
      send_point(rand_point());
    end
  endtask

  task automatic test_max_depth();
    write_reg(ptid_pkg::REG_DEPTH, 32'd27);
    write_reg(ptid_pkg::REG_TOL, 32'd0);
    for (int i = 0; i < 10; i++) send_point(rand_point());
    // values above the maximum saturate
    write_reg(ptid_pkg::REG_DEPTH, 32'hffff_ffff);
    write_reg(ptid_pkg::REG_TOL, 32'h0000_0001);
    for (int i = 0; i < 6; i++) send_point(rand_point());
  endtask

  // ---------------- receive side ----------------
  initial begin
    int k;
    @(posedge rst_ni);
    forever begin
      k = no_gaps ? 0 : $urandom_range(0, 10);
      if (k > 0) begin
        out_stall_i <= 1'b1;
        repeat (k) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o === 1'b1 && out_stall_i === 1'b0));
    end
  end

  always @(posedge clk_i) begin
    ptid_pkg::out_item_t exp_id;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_ids.size() == 0) begin
        $error("result with nothing expected: trixel_id %h", out_item_o.trixel_id);
        fail_count++;
      end else begin
        exp_id = pending_ids.pop_front();
        if (out_item_o.trixel_id !== exp_id.trixel_id) begin
          $error("trixel_id expected %h actual %h", exp_id.trixel_id, out_item_o.trixel_id);
          fail_count++;
        end
        if (out_item_o.no_match !== exp_id.no_match) begin
          $error("no_match expected %b actual %b", exp_id.no_match, out_item_o.no_match);
          fail_count++;
        end
      end
    end
  end

  // no handshake of any kind for too long means the block hung
  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_shallow_random(200, 5'd0, 20'd0);
    test_shallow_random(200, 5'd1, 20'd1);
    test_shallow_random(150, 5'd3, 20'hfffff);
    test_shallow_random(150, 5'd5, 20'(($urandom)));
    test_shallow_random(60, 5'd10, 20'd16);
    test_drain_pauses();
    test_max_depth();
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
